/* hw/rtl/clamped_pid_with_angle_wrap_assert.svh */
// Assertion macros for the clamped PID block.
// Define SYNTH to compile them out.
`ifndef CLAMPED_PID_WITH_ANGLE_WRAP_ASSERT_SVH
`define CLAMPED_PID_WITH_ANGLE_WRAP_ASSERT_SVH
`ifndef SYNTH
`define CPID_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cpid: property violated");
`define CPID_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("cpid: forbidden condition seen");
`else
`define CPID_ASSERT(lbl, clk, rst_n, prop)
`define CPID_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* hw/rtl/cpid_pkg.sv */
package cpid_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int GAIN_FRAC_BITS_DEF = 16;

    localparam int GAIN_W     = 32;
    localparam int LIM_W      = 31;
    localparam int MODE_W     = 2;
    localparam int DRIVE_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_P_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_I_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_D_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE = 3'd7;

    // loop modes
    localparam logic [MODE_W-1:0] MODE_POS       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POS_WRAP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POS_CLAMP = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INCR      = 2'd3;

    // input kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // 180 and 360 degrees in Q.6
    localparam int HALF_TURN = 180 * 64;
    localparam int FULL_TURN = 360 * 64;

    localparam logic [LIM_W-1:0] LIM_MAX = '1;

endpackage

/* hw/rtl/clamped_pid_with_angle_wrap.sv */
// Channel   Signals                                   Direction
// input     in_valid / in_stall, kind, target, measured   into the block
// result    out_valid / out_stall, drive              out of the block
// config    cfg_we, cfg_index, cfg_data               into the block, write only
//
// One transaction per cycle sustained while out_stall is low; each result passes
// the input register, then the result register, before out_valid is raised.
// The limiting path is the state feedback: error, gain multiply, term clamp,
// integral clamp and output sum/clamp are all combinational between registers.
// Reset clears the pipeline, the stored errors, integral and last drive, and
// puts the registers at gains 0, limits max, mode 2.
// A stalled result holds in the output register; the input register still
// takes one more transaction if it is empty, then in_stall rises.
module clamped_pid_with_angle_wrap #(
    parameter int SAMPLE_WIDTH   = cpid_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = cpid_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  kind,
    input  logic signed [SAMPLE_WIDTH-1:0]        target,
    input  logic signed [SAMPLE_WIDTH-1:0]        measured,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [cpid_pkg::DRIVE_W-1:0]   drive,
    input  logic                                  cfg_we,
    input  logic [cpid_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cpid_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import cpid_pkg::*;

    localparam int EW  = SAMPLE_WIDTH + 1;              // error width
    localparam int CW  = ((EW > 16) ? EW : 16) + 1;     // wrap compare width
    localparam int OW  = EW + 2;                        // multiplier operand width
    localparam int PW  = GAIN_W + OW;                   // product width
    localparam int QW  = PW - GAIN_FRAC_BITS;           // shifted product width
    localparam int XW  = (QW > DRIVE_W + 2) ? QW : DRIVE_W + 2;

    localparam logic signed [CW-1:0] HALF_C = CW'(HALF_TURN);
    localparam logic signed [CW-1:0] FULL_C = CW'(FULL_TURN);

    // configuration
    logic signed [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [LIM_W-1:0]         p_limit_reg, i_limit_reg, d_limit_reg, out_limit_reg;
    logic [MODE_W-1:0]        loop_mode_reg;

    // input register
    logic                           s1_valid_reg;
    logic                           s1_kind_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_target_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_measured_reg;

    // loop state
    logic signed [EW-1:0]      prev_err_reg, prev2_err_reg;
    logic signed [DRIVE_W-1:0] integral_reg, last_drive_reg;

    // result register
    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;

    logic advance;
    logic mode_incr, mode_wrap, mode_clamp;

    logic signed [CW-1:0]      err_raw, err_wrapped;
    logic signed [EW-1:0]      err;
    logic signed [OW-1:0]      diff1, diff2, op_p, op_d, op_i;
    logic signed [PW-1:0]      prod_p, prod_i, prod_d;
    logic signed [XW-1:0]      q_p, q_i, q_d;
    logic [LIM_W-1:0]          i_lim_sel;
    logic signed [DRIVE_W-1:0] term_p, term_i, term_d;
    logic signed [XW-1:0]      integ_sum;
    logic signed [DRIVE_W-1:0] integ_pos, integral_next, base;
    logic signed [XW-1:0]      drive_sum;
    logic signed [DRIVE_W-1:0] drive_calc;

    function automatic logic signed [DRIVE_W-1:0] clamp_sym(
        input logic signed [XW-1:0] x,
        input logic [LIM_W-1:0]     lim
    );
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = $signed(XW'(lim));
        lo = -hi;
        if (x > hi)
        begin
            clamp_sym = hi[DRIVE_W-1:0];
        end
        else if (x < lo)
        begin
            clamp_sym = lo[DRIVE_W-1:0];
        end
        else
        begin
            clamp_sym = x[DRIVE_W-1:0];
        end
    endfunction

    // two's complement saturation, one step wider on the negative side
    function automatic logic signed [DRIVE_W-1:0] sat_drive(
        input logic signed [XW-1:0] x
    );
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = $signed(XW'(LIM_MAX));
        lo = -hi - XW'(1);
        if (x > hi)
        begin
            sat_drive = hi[DRIVE_W-1:0];
        end
        else if (x < lo)
        begin
            sat_drive = lo[DRIVE_W-1:0];
        end
        else
        begin
            sat_drive = x[DRIVE_W-1:0];
        end
    endfunction

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    assign mode_incr  = (loop_mode_reg == MODE_INCR);
    assign mode_wrap  = (loop_mode_reg != MODE_POS);
    assign mode_clamp = (loop_mode_reg == MODE_POS_CLAMP) || (loop_mode_reg == MODE_INCR);

    always_comb
    begin
        err_raw = CW'(s1_target_reg) - CW'(s1_measured_reg);
        err_wrapped = err_raw;
        if (mode_wrap)
        begin
            if (err_raw > HALF_C)
            begin
                err_wrapped = err_raw - FULL_C;
            end
            else if (err_raw < -HALF_C)
            begin
                err_wrapped = err_raw + FULL_C;
            end
        end
        err = $signed(err_wrapped[EW-1:0]);

        diff1 = OW'(err) - OW'(prev_err_reg);
        diff2 = OW'(err) - (OW'(prev_err_reg) <<< 1) + OW'(prev2_err_reg);
        op_i  = OW'(err);
        op_p  = mode_incr ? diff1 : OW'(err);
        op_d  = mode_incr ? diff2 : diff1;

        prod_p = PW'(gain_p_reg) * PW'(op_p);
        prod_i = PW'(gain_i_reg) * PW'(op_i);
        prod_d = PW'(gain_d_reg) * PW'(op_d);

        // dropping the fraction bits rounds toward minus infinity
        q_p = XW'($signed(prod_p[PW-1:GAIN_FRAC_BITS]));
        q_i = XW'($signed(prod_i[PW-1:GAIN_FRAC_BITS]));
        q_d = XW'($signed(prod_d[PW-1:GAIN_FRAC_BITS]));

        i_lim_sel = mode_incr ? i_limit_reg : LIM_MAX;
        term_p = clamp_sym(q_p, p_limit_reg);
        term_i = clamp_sym(q_i, i_lim_sel);
        term_d = clamp_sym(q_d, d_limit_reg);

        integ_sum     = XW'(integral_reg) + XW'(term_i);
        integ_pos     = clamp_sym(integ_sum, i_limit_reg);
        integral_next = mode_incr ? term_i : integ_pos;

        base      = mode_incr ? last_drive_reg : '0;
        drive_sum = XW'(base) + XW'(term_p) + XW'(integral_next) + XW'(term_d);
        drive_calc = mode_clamp ? clamp_sym(drive_sum, out_limit_reg) : sat_drive(drive_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            p_limit_reg   <= LIM_MAX;
            i_limit_reg   <= LIM_MAX;
            d_limit_reg   <= LIM_MAX;
            out_limit_reg <= LIM_MAX;
            loop_mode_reg <= MODE_POS_CLAMP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAIN_P:    gain_p_reg    <= $signed(cfg_data);
                CFG_GAIN_I:    gain_i_reg    <= $signed(cfg_data);
                CFG_GAIN_D:    gain_d_reg    <= $signed(cfg_data);
                CFG_P_LIMIT:   p_limit_reg   <= cfg_data[LIM_W-1:0];
                CFG_I_LIMIT:   i_limit_reg   <= cfg_data[LIM_W-1:0];
                CFG_D_LIMIT:   d_limit_reg   <= cfg_data[LIM_W-1:0];
                CFG_OUT_LIMIT: out_limit_reg <= cfg_data[LIM_W-1:0];
                CFG_LOOP_MODE: loop_mode_reg <= cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_kind_reg     <= kind;
            s1_target_reg   <= target;
            s1_measured_reg <= measured;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            prev_err_reg   <= '0;
            prev2_err_reg  <= '0;
            integral_reg   <= '0;
            last_drive_reg <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                if (s1_kind_reg == KIND_CLEAR)
                begin
                    prev_err_reg   <= '0;
                    prev2_err_reg  <= '0;
                    integral_reg   <= '0;
                    last_drive_reg <= '0;
                end
                else
                begin
                    prev_err_reg   <= err;
                    integral_reg   <= integral_next;
                    last_drive_reg <= drive_calc;
                    if (mode_incr)
                    begin
                        prev2_err_reg <= prev_err_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            drive_reg <= (s1_kind_reg == KIND_CLEAR) ? '0 : drive_calc;
        end
    end

`include "clamped_pid_with_angle_wrap_assert.svh"

    `CPID_ASSERT(a_stall_needs_item, clk, rst_n, in_stall |-> s1_valid_reg)
    `CPID_ASSERT(a_result_tracks_state, clk, rst_n, out_valid_reg |-> drive_reg == last_drive_reg)
    `CPID_ASSERT(a_clear_zeroes_state, clk, rst_n, advance && s1_valid_reg && (s1_kind_reg == KIND_CLEAR) |=> integral_reg == '0 && prev_err_reg == '0 && prev2_err_reg == '0 && last_drive_reg == '0)
    `CPID_ASSERT_NEVER(a_result_from_nothing, clk, rst_n, $rose(out_valid_reg) && !$past(s1_valid_reg))

endmodule
